// File: sv/swbe_pkg.sv
// swbe_pkg: shared types and constants for the slice width block encoder
// no dependencies
`timescale 1ns / 1ps
package swbe_pkg;
   localparam int OUT_BITS  = 32;
   localparam int SLOT_BITS = 5;

   // controller to datapath
   typedef struct packed {
      logic load;      // store input word into pending lane
      logic pack;      // merge pending slice into lane words
      logic emit_sel;  // put selector on output register
      logic emit_lane; // put lane word at emit index on output register
      logic clear;     // clear the open block
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slice_done; // loaded word finished a slice
      logic overflow;   // slice does not fit in the open block
      logic fill;       // block full after pack
      logic last;       // slice ends the stream
   } status_type;
endpackage

// File: sv/swbe_if.sv
// swbe_if: valid/ready channel carrying a payload of a given width
// depends on nothing
`timescale 1ns / 1ps
interface swbe_if #(parameter int W = 33) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/swbe_datapath.sv
// swbe_datapath: pending slice, lane words, selector and output register
// depends on swbe_pkg
`timescale 1ns / 1ps
module swbe_datapath import swbe_pkg::*; #(
   parameter int LANES     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [$clog2(LANES)-1:0] emit_idx,
   input  logic                  in_last_flag,
   input  logic [OUT_BITS-1:0]   in_value,
   input  logic                  in_last,
   output status_type            status,
   output logic [OUT_BITS-1:0]   out_word,
   output logic [SLOT_BITS-1:0]  out_slot
);
   localparam int LB = $clog2(LANES);
   localparam int UB = $clog2(WORD_BITS + 1);
   localparam int PB = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] lane_ff [LANES];
   logic [OUT_BITS-1:0]  pend_ff [LANES];
   logic [WORD_BITS-1:0] sel_ff;
   logic [UB-1:0]        used_ff, used_in;
   logic [PB-1:0]        pos_ff;
   logic [LB-1:0]        lanepos_ff;
   logic [UB-1:0]        maxw_ff, maxw_in, sw_ff;
   logic [LB-1:0]        filled_ff;
   logic                 done_ff, last_ff;
   logic [UB-1:0]        w;
   logic [OUT_BITS-1:0]  out_word_ff;
   logic [SLOT_BITS-1:0] out_slot_ff;

   // bit length of the incoming value, clamped to 1..WORD_BITS
   always_comb begin
      w = UB'(1);
      for (int b = 0; b < OUT_BITS; b++)
         if (in_value[b]) w = (b + 1 > WORD_BITS) ? UB'(WORD_BITS) : UB'(b + 1);
   end

   assign maxw_in = (w > maxw_ff) ? w : maxw_ff;
   assign used_in = used_ff + sw_ff;
   assign status.slice_done = done_ff;
   assign status.last = last_ff;
   assign status.overflow = sw_ff > (UB'(WORD_BITS) - used_ff);
   assign status.fill = used_ff == UB'(WORD_BITS);
   assign out_word = out_word_ff;
   assign out_slot = out_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) lane_ff[i] <= '0;
         sel_ff <= '0; used_ff <= '0; pos_ff <= '0;
         lanepos_ff <= '0; maxw_ff <= '0; done_ff <= 1'b0;
         sw_ff <= '0; filled_ff <= '0; last_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            pend_ff[lanepos_ff] <= in_value;
            if (in_last || lanepos_ff == LB'(LANES - 1)) begin
               done_ff <= 1'b1; sw_ff <= maxw_in; maxw_ff <= '0;
               filled_ff <= lanepos_ff; lanepos_ff <= '0; last_ff <= in_last;
            end else begin
               done_ff <= 1'b0; maxw_ff <= maxw_in;
               lanepos_ff <= lanepos_ff + LB'(1);
            end
         end
         if (cmd.clear) begin
            for (int i = 0; i < LANES; i++) lane_ff[i] <= '0;
            sel_ff <= '0; used_ff <= '0; pos_ff <= '0;
         end
         if (cmd.pack) begin
            done_ff <= 1'b0;
            for (int i = 0; i < LANES; i++)
               if (LB'(i) <= filled_ff)
                  lane_ff[i] <= lane_ff[i] |
                     (WORD_BITS'(pend_ff[i]) << used_ff);
            pos_ff <= PB'(used_in - UB'(1));
            sel_ff <= sel_ff | (WORD_BITS'(1) << PB'(used_in - UB'(1)));
            // stream end pads the block to full width
            used_ff <= in_last_flag ? UB'(WORD_BITS) : used_in;
         end
      end
   end

   // output register; marker of newest slice moves to the top bit
   always_ff @(posedge clock) begin
      if (cmd.emit_sel) begin
         out_word_ff <= OUT_BITS'((sel_ff & ~(WORD_BITS'(1) << pos_ff)) |
                                  (WORD_BITS'(1) << (WORD_BITS - 1)));
         out_slot_ff <= '0;
      end else if (cmd.emit_lane) begin
         out_word_ff <= OUT_BITS'(lane_ff[emit_idx]);
         out_slot_ff <= SLOT_BITS'(emit_idx) + SLOT_BITS'(1);
      end
   end
endmodule

// File: sv/swbe_control.sv
// swbe_control: sequencer for load, pack and block emission
// depends on swbe_pkg
`timescale 1ns / 1ps
module swbe_control import swbe_pkg::*; #(
   parameter int LANES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic                     out_block_end,
   output logic                     out_stream_end,
   input  status_type               status,
   output cmd_type                  cmd,
   output logic [$clog2(LANES)-1:0] emit_idx,
   output logic                     last_flag
);
   localparam int LB = $clog2(LANES);
   localparam logic [1:0] S_IN = 2'd0, S_CHK = 2'd1, S_EMIT = 2'd2, S_PACK = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [LB:0]   cnt_ff, cnt_in;   // 0 selector, 1..LANES lanes
   logic          ov_ff, ov_in;     // emitting because of overflow
   logic          ovalid_ff, ovalid_in, bend_ff, bend_in, send_ff, send_in;
   logic          slot_free;

   assign slot_free = !ovalid_ff || out_ready;
   assign in_ready = state_ff == S_IN;
   assign out_valid = ovalid_ff;
   assign out_block_end = bend_ff;
   assign out_stream_end = send_ff;
   assign emit_idx = LB'(cnt_ff - (LB + 1)'(1));
   assign last_flag = status.last;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; ov_in = ov_ff;
      ovalid_in = ovalid_ff && !out_ready; bend_in = bend_ff; send_in = send_ff;
      cmd = '0;
      unique case (state_ff)
         S_IN: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (!status.slice_done) state_in = S_IN;
            else if (status.overflow) begin
               ov_in = 1'b1; cnt_in = '0; state_in = S_EMIT;
            end else state_in = S_PACK;
         end
         S_PACK: begin
            cmd.pack = 1'b1;
            if (status.last || status.overflow) begin
               // overflow here never holds after a fresh block
            end
            ov_in = 1'b0; cnt_in = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!ov_ff && !status.fill) state_in = S_IN;
            else if (slot_free) begin
               ovalid_in = 1'b1;
               cmd.emit_sel = cnt_ff == '0;
               cmd.emit_lane = cnt_ff != '0;
               bend_in = cnt_ff == (LB + 1)'(LANES);
               send_in = bend_in && !ov_ff && status.last;
               if (bend_in) begin
                  cmd.clear = 1'b1;
                  state_in = ov_ff ? S_PACK : S_IN;
               end
               cnt_in = cnt_ff + (LB + 1)'(1);
            end
         end
         default: state_in = S_IN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IN; cnt_ff <= '0; ov_ff <= 1'b0;
         ovalid_ff <= 1'b0; bend_ff <= 1'b0; send_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; ov_ff <= ov_in;
         ovalid_ff <= ovalid_in; bend_ff <= bend_in; send_ff <= send_in;
      end
   end
endmodule

// File: sv/slice_width_block_encoder_top.sv
// slice_width_block_encoder_top: packs slices of integers into selector plus lane blocks
// depends on swbe_pkg, swbe_if, swbe_control, swbe_datapath
//
// channel   dir  payload
// req       in   value[31:0], last
// rsp       out  word[31:0], word_slot[4:0], block_end, stream_end
//
// an integer passes the load and check states; a finished slice adds a pack state
// and an emit check state when no block closes
// a block emits LANES+1 words, one a cycle from the output register while rsp is not stalled
// a stalled rsp holds the sequencer; req is not taken while a block drains
// reset is synchronous and clears lane words, selector and counters
`timescale 1ns / 1ps
module slice_width_block_encoder_top import swbe_pkg::*; #(
   parameter int LANES     = 16,
   parameter int WORD_BITS = 32
) (
   input logic  clock,
   input logic  reset,
   swbe_if.sink   req,
   swbe_if.source rsp
);
   cmd_type    cmd;
   status_type status;
   logic [$clog2(LANES)-1:0] emit_idx;
   logic last_flag, bend, send;
   logic [OUT_BITS-1:0] word;
   logic [SLOT_BITS-1:0] slot;

   swbe_control #(.LANES(LANES)) u_ctl (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_block_end(bend),
      .out_stream_end(send), .status, .cmd, .emit_idx, .last_flag);

   swbe_datapath #(.LANES(LANES), .WORD_BITS(WORD_BITS)) u_dp (
      .clock, .reset, .cmd, .emit_idx, .in_last_flag(last_flag),
      .in_value(req.data[31:0]), .in_last(req.data[32]), .status,
      .out_word(word), .out_slot(slot));

   assign rsp.data = {send, bend, slot, word};
endmodule

// File: sv/swbe_checker.sv
// swbe_checker: port level checks for the encoder
// depends on slice_width_block_encoder_top
`timescale 1ns / 1ps
module swbe_checker (
   input logic clock, input logic reset,
   input logic rv, input logic rr, input logic [38:0] rd,
   input logic qr
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv && !rr |=> rv && $stable(rd)) else $error("rsp dropped");
   a_send: assert property (@(posedge clock) disable iff (reset)
      rv && rd[38] |-> rd[37]) else $error("stream end off block end");
   a_bend: assert property (@(posedge clock) disable iff (reset)
      rv && rd[37] |-> rd[36:32] == 5'd16) else $error("block end slot");
   // only the closing word of a block may still wait while input is open
   a_noin: assert property (@(posedge clock) disable iff (reset)
      rv && qr |-> rd[37]) else $error("input taken while draining");
endmodule

bind slice_width_block_encoder_top swbe_checker u_chk (
   .clock, .reset, .rv(rsp.valid), .rr(rsp.ready), .rd(rsp.data),
   .qr(req.ready));
